/* rtl/omamm_pkg.sv */
// shared types and constants of the offset moving average block
package omamm_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned WINDOW_DEF    = 16;
  localparam int unsigned CAL_COUNT_DEF = 100;
  // dividend width of the shared reciprocal divider, covers WINDOW up to 256
  localparam int unsigned DIV_W         = 24;

  localparam logic signed [SAMPLE_W-1:0] RAW_MAX   = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] RAW_MIN   = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7fff;

  typedef enum logic {
    ACT_CAL  = 1'b0,
    ACT_MEAS = 1'b1
  } action_e;

  typedef struct packed {
    action_e                     action;
    logic signed [SAMPLE_W-1:0]  sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  smoothed;
    logic signed [SAMPLE_W-1:0]  raw_value;
    logic        [SAMPLE_W-2:0]  peak_high;
    logic signed [SAMPLE_W-1:0]  peak_low;
    logic signed [SAMPLE_W-1:0]  zero_offset;
    logic                        cal_done;
  } out_t;

endpackage

/* rtl/omamm_ring.sv */
// sample ring memory with registered read data and per-entry valid bits
module omamm_ring #(
  parameter int unsigned DEPTH = omamm_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic [omamm_pkg::SAMPLE_W-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic [omamm_pkg::SAMPLE_W-1:0] wr_data_i
);

  logic [omamm_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [omamm_pkg::SAMPLE_W-1:0] rdata_q;
  logic [DEPTH-1:0]               valid_q;
  logic                           rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never written entries read as zero
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/offset_moving_average_minmax.sv */
// top level: zero-offset calibration, moving average and peak tracking
//
// Input channel in_valid_i/in_ready_o carries one sample, tagged as
// calibration or measurement. Output channel out_valid_o/out_ready_i returns
// exactly one result per input transfer, in order.
// From input transfer to output valid an item passes ring read, sum/peak
// update with ring write-back, absolute value, reciprocal multiply, and shift
// and sign fix-up into the output register. Throughput is one item per cycle
// while the receiver keeps up. A calibration item that closes a run holds
// in_ready_o low until its offset has passed the shared reciprocal multiplier
// and is written, so that following measurements use it.
// Each stage moves on when the stage after it is empty or moving, so the
// block keeps taking items into empty stages while the receiver stalls; a
// full pipeline with a stalled output drops in_ready_o.
// Reset clears the running sums, peaks, offset and calibration progress; the
// ring reads as all zeros through per-entry valid bits, so no clearing pass
// is needed and items are taken right after reset.
module offset_moving_average_minmax #(
  parameter int unsigned WINDOW    = omamm_pkg::WINDOW_DEF,
  parameter int unsigned CAL_COUNT = omamm_pkg::CAL_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  omamm_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output omamm_pkg::out_t  out_data_o
);

  localparam int unsigned W      = omamm_pkg::SAMPLE_W;
  localparam int unsigned DW     = omamm_pkg::DIV_W;
  localparam int unsigned AW     = $clog2(WINDOW);
  localparam int unsigned SUM_W  = W + $clog2(WINDOW);
  localparam int unsigned CAL_W  = W + $clog2(CAL_COUNT);
  localparam int unsigned CNT_W  = $clog2(CAL_COUNT + 1);
  localparam int unsigned PROD_W = 2 * DW + 1;
  localparam int unsigned SH_WIN = DW + $clog2(WINDOW);
  localparam int unsigned SH_CAL = DW + $clog2(CAL_COUNT);
  localparam logic [63:0] M_WIN_FULL =
    ((64'd1 << SH_WIN) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [63:0] M_CAL_FULL =
    ((64'd1 << SH_CAL) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);
  localparam logic [DW:0] M_WIN = M_WIN_FULL[DW:0];
  localparam logic [DW:0] M_CAL = M_CAL_FULL[DW:0];

  typedef struct packed {
    omamm_pkg::action_e      action;
    logic signed [W-1:0]     sample;
    logic                    done;
    logic [AW-1:0]           slot;
    logic signed [CAL_W-1:0] cal_sum;
  } s1_t;

  typedef struct packed {
    logic                meas;
    logic                done;
    logic signed [W-1:0] raw;
    logic signed [W-1:0] maxv;
    logic signed [W-1:0] minv;
  } info_t;

  // control and state
  logic                    s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic                    pending_q;
  logic [AW-1:0]           slot_q;
  logic signed [SUM_W-1:0] win_sum_q;
  logic signed [CAL_W-1:0] cal_acc_q;
  logic [CNT_W-1:0]        cal_cnt_q;
  logic signed [W-1:0]     offset_q;
  logic signed [W-1:0]     max_q;
  logic signed [W-1:0]     min_q;
  logic signed [W-1:0]     last_raw_q;
  logic signed [W-1:0]     last_mean_q;

  // payload
  s1_t                     s1_q;
  info_t                   s2_q, s3_q, s4_q;
  logic signed [DW-1:0]    s2_val_q;
  logic [DW-1:0]           s3_abs_q;
  logic                    s3_neg_q, s4_neg_q;
  logic [PROD_W-1:0]       s4_prod_q;
  omamm_pkg::out_t         out_q;

  logic en_out, en4, en3, en2, en1;
  logic accept, s1_move, s4_move;

  assign en_out = !out_v_q || out_ready_i;
  assign en4    = !s4_v_q || en_out;
  assign en3    = !s3_v_q || en4;
  assign en2    = !s2_v_q || en3;
  assign en1    = !s1_v_q || en2;

  assign in_ready_o = en1 && !pending_q;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_move    = s1_v_q && en2;
  assign s4_move    = s4_v_q && en_out;

  // calibration accumulate at transfer
  logic signed [CAL_W-1:0] cal_sum;
  logic [CNT_W-1:0]        cal_cnt_inc;
  logic                    cal_close;
  logic                    is_meas_in;

  assign is_meas_in  = (in_data_i.action == omamm_pkg::ACT_MEAS);
  assign cal_sum     = cal_acc_q + CAL_W'(in_data_i.sample);
  assign cal_cnt_inc = cal_cnt_q + CNT_W'(1);
  assign cal_close   = (cal_cnt_inc == CNT_W'(CAL_COUNT));

  // ring memory
  logic [W-1:0]        ring_rdata;
  logic                ring_we;
  logic signed [W-1:0] raw_new;

  assign ring_we = s1_move && (s1_q.action == omamm_pkg::ACT_MEAS);

  omamm_ring #(
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && is_meas_in),
    .rd_addr_i (slot_q),
    .rd_data_o (ring_rdata),
    .wr_en_i   (ring_we),
    .wr_addr_i (s1_q.slot),
    .wr_data_i (raw_new)
  );

  // offset subtraction, running sum and peaks
  logic signed [W:0]       diff;
  logic signed [W-1:0]     old_val;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [W-1:0]     max_new;
  logic signed [W-1:0]     min_new;
  info_t                   s2_d;

  assign diff    = $signed({s1_q.sample[W-1], s1_q.sample})
                 - $signed({offset_q[W-1], offset_q});
  assign raw_new = (diff[W] != diff[W-1]) ?
                   (diff[W] ? omamm_pkg::RAW_MIN : omamm_pkg::RAW_MAX) : diff[W-1:0];
  assign old_val = $signed(ring_rdata);
  assign sum_new = win_sum_q - SUM_W'(old_val) + SUM_W'(raw_new);
  assign max_new = (raw_new > max_q) ? raw_new : max_q;
  assign min_new = (raw_new < min_q) ? raw_new : min_q;

  always_comb begin
    s2_d.meas = (s1_q.action == omamm_pkg::ACT_MEAS);
    s2_d.done = s1_q.done;
    if (s2_d.meas) begin
      s2_d.raw  = raw_new;
      s2_d.maxv = max_new;
      s2_d.minv = min_new;
    end else begin
      s2_d.raw  = last_raw_q;
      s2_d.maxv = max_q;
      s2_d.minv = min_q;
    end
  end

  // reciprocal divider tail
  logic [PROD_W-1:0] q_win, q_cal;
  logic [W:0]        q_mag, q_sgn;
  omamm_pkg::out_t   out_d;

  assign q_win = s4_prod_q >> SH_WIN;
  assign q_cal = s4_prod_q >> SH_CAL;
  assign q_mag = s4_q.meas ? q_win[W:0] : q_cal[W:0];
  assign q_sgn = s4_neg_q ? (~q_mag + (W+1)'(1)) : q_mag;

  always_comb begin
    out_d.smoothed    = s4_q.meas ? $signed(q_sgn[W-1:0]) : last_mean_q;
    out_d.raw_value   = s4_q.raw;
    out_d.peak_high   = s4_q.maxv[W-2:0];
    out_d.peak_low    = s4_q.minv;
    out_d.zero_offset = s4_q.done ? $signed(q_sgn[W-1:0]) : offset_q;
    out_d.cal_done    = s4_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      pending_q   <= 1'b0;
      slot_q      <= '0;
      win_sum_q   <= '0;
      cal_acc_q   <= '0;
      cal_cnt_q   <= '0;
      offset_q    <= '0;
      max_q       <= '0;
      min_q       <= omamm_pkg::MIN_RESET;
      last_raw_q  <= '0;
      last_mean_q <= '0;
    end else begin
      if (en1)    s1_v_q  <= accept;
      if (en2)    s2_v_q  <= s1_v_q;
      if (en3)    s3_v_q  <= s2_v_q;
      if (en4)    s4_v_q  <= s3_v_q;
      if (en_out) out_v_q <= s4_v_q;

      if (accept) begin
        if (is_meas_in) begin
          slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + AW'(1);
        end else if (cal_close) begin
          cal_acc_q <= '0;
          cal_cnt_q <= '0;
          pending_q <= 1'b1;
        end else begin
          cal_acc_q <= cal_sum;
          cal_cnt_q <= cal_cnt_inc;
        end
      end

      if (ring_we) begin
        win_sum_q  <= sum_new;
        last_raw_q <= raw_new;
        max_q      <= max_new;
        min_q      <= min_new;
      end

      if (s4_move) begin
        if (s4_q.meas) begin
          last_mean_q <= $signed(q_sgn[W-1:0]);
        end
        if (s4_q.done) begin
          offset_q  <= $signed(q_sgn[W-1:0]);
          pending_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && accept) begin
      s1_q.action  <= in_data_i.action;
      s1_q.sample  <= in_data_i.sample;
      s1_q.done    <= !is_meas_in && cal_close;
      s1_q.slot    <= slot_q;
      s1_q.cal_sum <= cal_sum;
    end
    if (s1_move) begin
      s2_q     <= s2_d;
      s2_val_q <= s2_d.meas ? DW'(sum_new) : DW'(s1_q.cal_sum);
    end
    if (en3 && s2_v_q) begin
      s3_q     <= s2_q;
      s3_neg_q <= s2_val_q[DW-1];
      s3_abs_q <= s2_val_q[DW-1] ? (~s2_val_q + DW'(1)) : s2_val_q;
    end
    if (en4 && s3_v_q) begin
      s4_q      <= s3_q;
      s4_neg_q  <= s3_neg_q;
      s4_prod_q <= PROD_W'(s3_abs_q) * PROD_W'(s3_q.meas ? M_WIN : M_CAL);
    end
    if (s4_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* tb/sv/offset_moving_average_minmax_tb.sv */
// testbench for offset_moving_average_minmax: random calibration runs and measurements against a predictor
module offset_moving_average_minmax_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import omamm_pkg::*;

  localparam int WIN      = int'(WINDOW_DEF);
  localparam int CAL_N    = int'(CAL_COUNT_DEF);
  localparam int N_ITEMS  = 650;
  localparam int LIMIT    = 200000;
  localparam int MAX_SHOW = 10;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  in_t  sample_fifo[$];
  out_t result_due[$];
  int   send_idle_pct  = 20;
  int   recv_stall_pct = 63;
  int   mismatch_cnt   = 0;
  int   cycles         = 0;
  int   added          = 0;

  // predictor state
  logic signed [15:0] ring_q[WIN];
  int                 slot_q;
  int                 ring_sum;
  logic signed [15:0] offset_q;
  int                 cal_sum;
  int                 cal_seen;
  int                 peak_hi;
  int                 peak_lo;
  logic signed [15:0] raw_q;
  logic signed [15:0] mean_q;

  offset_moving_average_minmax DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_predictor();
    for (int i = 0; i < WIN; i++) ring_q[i] = '0;
    slot_q   = 0;
    ring_sum = 0;
    offset_q = '0;
    cal_sum  = 0;
    cal_seen = 0;
    peak_hi  = 0;
    peak_lo  = 32767;
    raw_q    = '0;
    mean_q   = '0;
  endfunction

  function automatic void predict_reading(in_t it);
    out_t r;
    int   diff;
    r = '0;
    if (it.action == ACT_CAL) begin
      cal_sum += int'(it.sample);
      cal_seen++;
      if (cal_seen >= CAL_N) begin
        offset_q   = 16'(cal_sum / CAL_N);
        cal_sum    = 0;
        cal_seen   = 0;
        r.cal_done = 1'b1;
      end
    end else begin
      diff = int'(it.sample) - int'(offset_q);
      if (diff > 32767) diff = 32767;
      if (diff < -32768) diff = -32768;
      ring_sum -= int'(ring_q[slot_q]);
      ring_q[slot_q] = 16'(diff);
      ring_sum += diff;
      slot_q = (slot_q + 1 >= WIN) ? 0 : slot_q + 1;
      raw_q  = 16'(diff);
      mean_q = 16'(ring_sum / WIN);
      if (diff > peak_hi) peak_hi = diff;
      if (diff < peak_lo) peak_lo = diff;
    end
    r.smoothed    = mean_q;
    r.raw_value   = raw_q;
    r.peak_high   = 15'(peak_hi);
    r.peak_low    = 16'(peak_lo);
    r.zero_offset = offset_q;
    result_due.push_back(r);
  endfunction

  function automatic void add_sample(action_e act, int v);
    in_t it;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    it.action = act;
    it.sample = 16'(v);
    sample_fifo.push_back(it);
    added++;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(5))
      0: return ($urandom_range(1) != 0) ? 32767 : -32768;
      1: return int'($urandom_range(200)) - 100;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // one calibration run with stray measurements, or a burst of measurements
  function automatic void add_random_block();
    int base;
    int spread;
    int n;
    if ($urandom_range(99) < 55) begin
      case ($urandom_range(3))
        0: base = 32767;
        1: base = -32768;
        default: base = int'($urandom_range(65535)) - 32768;
      endcase
      spread = ($urandom_range(1) != 0) ? 0 : int'($urandom_range(4000));
      n = 0;
      while (n < CAL_N) begin
        if ($urandom_range(99) < 10) begin
          add_sample(ACT_MEAS, rand_sample());
        end else begin
          add_sample(ACT_CAL, base + int'($urandom_range(2 * spread)) - spread);
          n++;
        end
      end
    end else begin
      n = $urandom_range(40, 5);
      for (int i = 0; i < n; i++) add_sample(ACT_MEAS, rand_sample());
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_reading(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= sample_fifo.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOW) begin
            $display("unexpected result transfer: %p", out_data_o);
          end
        end else begin
          exp_r = result_due.pop_front();
          if (out_data_o !== exp_r) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOW) begin
              $display("mismatch (exp/act): smoothed %0d/%0d raw %0d/%0d high %0d/%0d",
                       exp_r.smoothed, out_data_o.smoothed, exp_r.raw_value,
                       out_data_o.raw_value, exp_r.peak_high, out_data_o.peak_high);
              $display("  low %0d/%0d offset %0d/%0d done %0b/%0b",
                       exp_r.peak_low, out_data_o.peak_low, exp_r.zero_offset,
                       out_data_o.zero_offset, exp_r.cal_done, out_data_o.cal_done);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clear_predictor();
    // ring filling from zero, field extremes, partial calibration across measurements
    add_sample(ACT_MEAS, 0);
    add_sample(ACT_MEAS, 32767);
    add_sample(ACT_MEAS, -32768);
    add_sample(ACT_MEAS, 1);
    add_sample(ACT_MEAS, -1);
    add_sample(ACT_MEAS, 16'sh5555);
    add_sample(ACT_MEAS, -21846);
    add_sample(ACT_CAL, 32767);
    add_sample(ACT_CAL, -32768);
    add_sample(ACT_MEAS, 100);
    add_sample(ACT_CAL, 0);
    add_sample(ACT_CAL, -1);
    add_sample(ACT_MEAS, -100);
    for (int i = 0; i < 8; i++) add_sample(ACT_MEAS, 32767 - i);
    add_sample(ACT_MEAS, -32768);
    add_sample(ACT_MEAS, 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (added < N_ITEMS / 3) add_random_block();
    while (sample_fifo.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_idle_pct  = 63;
    recv_stall_pct = 20;
    while (added < 2 * N_ITEMS / 3) add_random_block();
    while (sample_fifo.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (added < N_ITEMS) add_random_block();

    while (sample_fifo.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/omamm_pkg.sv
rtl/omamm_ring.sv
rtl/offset_moving_average_minmax.sv
tb/sv/offset_moving_average_minmax_tb.sv
